FILE: rtl/fws_pkg.sv
// Package for the flag word stack: sizes, operation and status codes,
// and the request and result payload types.
// Depends on nothing; used by flag_word_stack.
package fws_pkg;

    localparam int DEPTH      = 32;
    localparam int FLAG_WIDTH = 8;
    localparam int PTR_W      = $clog2(DEPTH);

    localparam logic [FLAG_WIDTH-1:0] DEFAULT_FLAGS = '0;

    localparam logic [2:0] FUNC_LOAD = 3'd0;
    localparam logic [2:0] FUNC_OR   = 3'd1;
    localparam logic [2:0] FUNC_CLR  = 3'd2;
    localparam logic [2:0] FUNC_PUSH = 3'd3;
    localparam logic [2:0] FUNC_POP  = 3'd4;
    localparam logic [2:0] FUNC_SWAP = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] flag_value;
    } t_req;

    typedef struct packed {
        logic [7:0] top_flags;
        logic [4:0] stack_level;
        logic [1:0] status;
    } t_rsp;

endpackage

FILE: rtl/flag_word_stack.sv
// Flag word stack: load, or, clear, push, a refused pop and an unknown code are
// answered from the request itself; pop and swap also pass through a read state,
// stalling the input while they wait on the registered read of the entry store.
// Every request gives one result, held in an output register until taken.
// Reset (i_rst_n low, synchronous) clears the level, the top word, the
// entry valid bits and both handshakes at once; no clearing pass is needed.
// Depends on fws_pkg.
module flag_word_stack import fws_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] ONE_IDX  = PTR_W'(1);

    // The top word lives in r_top; the store holds the entries beneath it and
    // the last contents of entries above it.
    logic [FLAG_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      r_vld;
    logic [FLAG_WIDTH-1:0] r_rd_data;
    logic                  r_rd_vld;

    logic                  r_state, n_state;
    logic [PTR_W-1:0]      r_sp, n_sp;
    logic [FLAG_WIDTH-1:0] r_top, n_top;
    logic                  r_out_vld, n_out_vld;
    t_rsp                  r_out, n_out;

    logic                  accept, out_free;
    logic                  mem_we, mem_re;
    logic [PTR_W-1:0]      wr_addr, rd_addr, other;
    logic [FLAG_WIDTH-1:0] val, rd_word;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = (r_state == ST_READ) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign val        = i_in_data.flag_value[FLAG_WIDTH-1:0];
    assign other      = (r_sp == '0) ? ONE_IDX : r_sp - ONE_IDX;
    assign rd_word    = r_rd_vld ? r_rd_data : '0;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_sp      = r_sp;
        n_top     = r_top;
        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        wr_addr   = r_sp;
        rd_addr   = other;
        if (r_state == ST_READ) begin
            n_top     = rd_word;
            n_state   = ST_IDLE;
            n_out_vld = 1'b1;
            n_out     = '{top_flags: 8'(rd_word), stack_level: 5'(r_sp),
                          status: STATUS_OK};
        end else if (accept) begin
            n_out_vld = 1'b1;
            n_out     = '{top_flags: 8'(r_top), stack_level: 5'(r_sp),
                          status: STATUS_OK};
            unique case (i_in_data.func)
                FUNC_LOAD: n_top = val;
                FUNC_OR:   n_top = r_top | val;
                FUNC_CLR:  n_top = r_top & ~val;
                FUNC_PUSH: begin
                    if (r_sp == LAST_IDX) begin
                        n_out.status = STATUS_OVERFLOW;
                    end else begin
                        // The old top is written back; the new top is its copy.
                        mem_we  = 1'b1;
                        wr_addr = r_sp;
                        n_sp    = r_sp + ONE_IDX;
                    end
                end
                FUNC_POP: begin
                    if (r_sp == '0) begin
                        n_out.status = STATUS_UNDERFLOW;
                    end else begin
                        mem_we    = 1'b1;
                        wr_addr   = r_sp;
                        mem_re    = 1'b1;
                        rd_addr   = r_sp - ONE_IDX;
                        n_sp      = r_sp - ONE_IDX;
                        n_state   = ST_READ;
                        n_out_vld = 1'b0;
                    end
                end
                FUNC_SWAP: begin
                    // Read-before-write on the same entry gives the old word.
                    mem_we    = 1'b1;
                    wr_addr   = other;
                    mem_re    = 1'b1;
                    rd_addr   = other;
                    n_state   = ST_READ;
                    n_out_vld = 1'b0;
                end
                default: ;
            endcase
            if (n_state == ST_IDLE) begin
                n_out.top_flags   = 8'(n_top);
                n_out.stack_level = 5'(n_sp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_top;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_re) begin
                r_rd_vld <= r_vld[rd_addr];
            end
            if (mem_we) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= '0;
            r_top     <= DEFAULT_FLAGS;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_top     <= n_top;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for flag_word_stack: directed, back-pressure and random tests
// against a cycle-free predictor of the stack, with random idling on both channels.
// Depends on fws_pkg and flag_word_stack.
module tb;
    import fws_pkg::*;

    localparam logic [2:0] FUNC_UNDEF_LO = 3'd6;
    localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;
    localparam int MAX_SHOWN     = 10;
    localparam int TAIL_CYCLES   = 8;
    localparam int IDLE_PCT      = 17;
    localparam int RANDOM_ITEMS  = 1500;
    localparam longint LIMIT_NS  = 3000000;

    typedef enum int {TREND_FLAT, TREND_RISE, TREND_FALL} t_trend;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out_data;

    flag_word_stack dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Predicted copy of the stack.
    logic [FLAG_WIDTH-1:0] pred_store [DEPTH];
    logic [PTR_W-1:0]      pred_top;

    t_rsp expected_rsp_q [$];

    int tx_idle_pct  = IDLE_PCT;
    int rx_stall_pct = IDLE_PCT;
    int rx_hold_left = 0;

    int n_sent      = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int n_overflow  = 0;
    int n_underflow = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_req mk_req(logic [2:0] func, logic [7:0] flags);
        t_req r;
        r.func       = func;
        r.flag_value = flags;
        return r;
    endfunction

    function automatic t_rsp apply_stack_op(t_req r);
        t_rsp                  rsp;
        logic [1:0]            st;
        logic [PTR_W-1:0]      other;
        logic [FLAG_WIDTH-1:0] tmp;
        st = STATUS_OK;
        case (r.func)
            FUNC_LOAD: pred_store[pred_top] = r.flag_value;
            FUNC_OR:   pred_store[pred_top] = pred_store[pred_top] | r.flag_value;
            FUNC_CLR:  pred_store[pred_top] = pred_store[pred_top] & ~r.flag_value;
            FUNC_PUSH: begin
                if (pred_top == DEPTH - 1) begin
                    st = STATUS_OVERFLOW;
                end else begin
                    pred_store[pred_top + 1] = pred_store[pred_top];
                    pred_top = pred_top + 1'b1;
                end
            end
            FUNC_POP: begin
                if (pred_top == 0) begin
                    st = STATUS_UNDERFLOW;
                end else begin
                    pred_top = pred_top - 1'b1;
                end
            end
            FUNC_SWAP: begin
                // At the bottom the swap partner is the entry above instead.
                other = (pred_top == 0) ? PTR_W'(1) : pred_top - 1'b1;
                tmp = pred_store[pred_top];
                pred_store[pred_top] = pred_store[other];
                pred_store[other] = tmp;
            end
            default: ;
        endcase
        rsp.top_flags   = pred_store[pred_top];
        rsp.stack_level = pred_top;
        rsp.status      = st;
        return rsp;
    endfunction

    // Entered just after a rising edge; returns at the edge that accepts the request.
    task automatic send_req(t_req r);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        expected_rsp_q.push_back(apply_stack_op(r));
        n_sent++;
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_stall <= 1'b1;
                rx_hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rsp_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("%0t: result with nothing outstanding: flags %02h level %0d status %0d",
                             $realtime, o_out_data.top_flags, o_out_data.stack_level,
                             o_out_data.status);
            end else begin
                want = expected_rsp_q.pop_front();
                n_checked++;
                if (want.status == STATUS_OVERFLOW) n_overflow++;
                if (want.status == STATUS_UNDERFLOW) n_underflow++;
                if (o_out_data.top_flags !== want.top_flags ||
                    o_out_data.stack_level !== want.stack_level ||
                    o_out_data.status !== want.status) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("%0t: mismatch: flags %02h/%02h level %0d/%0d status %0d/%0d %s",
                                 $realtime, o_out_data.top_flags, want.top_flags,
                                 o_out_data.stack_level, want.stack_level,
                                 o_out_data.status, want.status, "(got/expected)");
                end
            end
        end
    end

    task automatic test_directed();
        send_req(mk_req(FUNC_LOAD, 8'hFF));
        send_req(mk_req(FUNC_CLR,  8'h0F));
        send_req(mk_req(FUNC_OR,   8'h05));
        send_req(mk_req(FUNC_LOAD, 8'h00));
        send_req(mk_req(FUNC_OR,   8'hFF));
        send_req(mk_req(FUNC_CLR,  8'hFF));
        send_req(mk_req(FUNC_POP,  8'h00));      // refused at the bottom
        send_req(mk_req(FUNC_LOAD, 8'hA5));
        send_req(mk_req(FUNC_SWAP, 8'hFF));      // bottom swap with entry one
        send_req(mk_req(FUNC_PUSH, 8'h00));
        send_req(mk_req(FUNC_LOAD, 8'h3C));
        send_req(mk_req(FUNC_SWAP, 8'h00));
        send_req(mk_req(FUNC_POP,  8'hFF));
        send_req(mk_req(FUNC_UNDEF_LO, 8'hFF));
        send_req(mk_req(FUNC_UNDEF_HI, 8'h00));
        send_req(mk_req(FUNC_PUSH, 8'hFF));
        send_req(mk_req(FUNC_PUSH, 8'h81));
        send_req(mk_req(FUNC_POP,  8'h7E));
        send_req(mk_req(FUNC_POP,  8'h00));
        wait_drain();
    endtask

    // Fill the stack past full while the receiver holds off, then empty it past the bottom.
    task automatic test_full_stack();
        rx_hold_left = 80;
        for (int k = 0; k < DEPTH + 8; k++)
            send_req(mk_req(FUNC_PUSH, 8'($urandom)));
        send_req(mk_req(FUNC_LOAD, 8'h96));
        send_req(mk_req(FUNC_SWAP, 8'h00));
        send_req(mk_req(FUNC_OR,   8'h41));
        for (int k = 0; k < DEPTH + 4; k++)
            send_req(mk_req(FUNC_POP, 8'($urandom)));
        wait_drain();
    endtask

    function automatic logic [2:0] pick_func(t_trend tr);
        int pick;
        int push_w;
        int pop_w;
        pick = $urandom_range(99);
        if (pick < 4) return pick[0] ? FUNC_UNDEF_HI : FUNC_UNDEF_LO;
        case (tr)
            TREND_RISE: begin push_w = 45; pop_w = 10; end
            TREND_FALL: begin push_w = 10; pop_w = 45; end
            default:    begin push_w = 20; pop_w = 20; end
        endcase
        pick = $urandom_range(99);
        if (pick < push_w) return FUNC_PUSH;
        if (pick < push_w + pop_w) return FUNC_POP;
        case (pick % 4)
            0:       return FUNC_LOAD;
            1:       return FUNC_OR;
            2:       return FUNC_CLR;
            default: return FUNC_SWAP;
        endcase
    endfunction

    task automatic test_random();
        t_trend trend;
        trend = TREND_FLAT;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 64 == 0) trend = t_trend'($urandom_range(2));
            if (k == 600) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            if (k == 900) begin
                tx_idle_pct  = IDLE_PCT;
                rx_stall_pct = IDLE_PCT;
            end
            if (k == 1000) wait_drain();
            if (k == 1200) rx_hold_left = 50;
            send_req(mk_req(pick_func(trend), 8'($urandom)));
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        for (int k = 0; k < DEPTH; k++) pred_store[k] = '0;
        pred_store[0] = DEFAULT_FLAGS;
        pred_top = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_stack();
        test_random();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d results.", n_sent, n_checked);
        $display("Refused pushes at full: %0d, refused pops at the bottom: %0d.",
                 n_overflow, n_underflow);
        if (n_errors == 0 && expected_rsp_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
